/* hw/rtl/quicksort_median_of_three_sorter_unit_macros.svh */
// Assertion macros used by the checker file.
`ifndef QUICKSORT_MEDIAN_OF_THREE_SORTER_UNIT_MACROS_SVH
`define QUICKSORT_MEDIAN_OF_THREE_SORTER_UNIT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define QS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define QS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/qsm3_pkg.sv */
// ----------------------------------------------------------------------------
// qsm3_pkg
// The shared sequencer state type of the quicksort sorter.
// ----------------------------------------------------------------------------
package qsm3_pkg;

  // Sequencer states of the sorter core.
  typedef enum logic [4:0] {
    ST_LOAD,
    ST_POP_REQ,
    ST_POP_WAIT,
    ST_RANGE,
    ST_RD_MID,
    ST_RD_LAST,
    ST_CAP_LAST,
    ST_SORT_BC,
    ST_SORT_AB,
    ST_WR_FIRST,
    ST_WR_MID,
    ST_WR_LAST,
    ST_PT_RD,
    ST_PT_CMP,
    ST_PT_SW,
    ST_PT_SW2,
    ST_FIN_RD,
    ST_FIN_WR,
    ST_FIN_WR2,
    ST_PUSH1,
    ST_PUSH2,
    ST_OUT_RD,
    ST_OUT_WAIT
  } qsm3_state_t;

endpackage

/* hw/rtl/qsm3_stream_if.sv */
// ----------------------------------------------------------------------------
// qsm3_stream_if
// Valid/ready channel carrying the sorter payloads.
// ----------------------------------------------------------------------------
interface qsm3_stream_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] value;
  logic                  last;
  logic                  overflow;

  modport source (output valid, output value, output last, output overflow, input ready);
  modport sink (input valid, input value, input last, input overflow, output ready);
endinterface

/* hw/rtl/quicksort_median_of_three_sorter_unit.sv */
// ----------------------------------------------------------------------------
// quicksort_median_of_three_sorter_unit
// Collects a set of values, sorts it by quicksort and streams it out.
// ----------------------------------------------------------------------------
// Usage: the in channel takes one value per item, one item per cycle; the
// item with last set closes the set. Items beyond MAX_ITEMS are dropped and
// the overflow flag marks every result of that run. After the closing item
// in.ready stays low until the final result sits in the output register.
// Sorting uses a median-of-three pivot, a Lomuto partition and a range
// stack; the values and the stack sit in memories with a registered read.
// Each range is popped from the stack (the first range skips this), its
// pivot is set up, the scan starts, each scanned element below the pivot
// is swapped down, the pivot is placed and the two sub-ranges are pushed;
// a range of two is only sorted in place. A badly ordered set can cost
// quadratic time. Results leave one at a time, each read from the store
// before it is loaded, and wait in the output register while the receiver
// stalls. A one-item set skips sorting and goes straight to the output
// read. Reset (rst, synchronous) empties the set and returns to loading;
// the memories need no clearing.
// ----------------------------------------------------------------------------
module quicksort_median_of_three_sorter_unit #(
  parameter int MAX_ITEMS  = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  qsm3_stream_if.sink    in_ch,
  qsm3_stream_if.source  out_ch
);
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = AW + 1;

  typedef logic [AW-1:0]         idx_t;
  typedef logic [DATA_WIDTH-1:0] val_t;

  // Element store and range stack.
  val_t            store [MAX_ITEMS];
  logic [2*AW-1:0] stack [MAX_ITEMS];

  qsm3_pkg::qsm3_state_t state, state_next;
  logic [CW-1:0] count;
  logic          ovf;
  logic [CW-1:0] sp;
  idx_t first, last, mid, k, low_end, oidx;
  val_t a, b, c, pivot, rd;
  logic [2*AW-1:0] srd;

  // Store port controls.
  logic  we;
  idx_t  wa, ra;
  val_t  wd;
  logic  swe;
  logic [2*AW-1:0] swd;
  idx_t  sra;

  assign sra = sp[AW-1:0] - idx_t'(1);

  always_ff @(posedge clk) begin
    if (we) store[wa] <= wd;
    rd <= store[ra];
    if (swe) stack[sp[AW-1:0]] <= swd;
    srd <= stack[sra];
  end

  // Output register.
  logic ov;
  val_t ovl;
  logic olast;
  logic oovf;

  assign in_ch.ready     = (state == qsm3_pkg::ST_LOAD);
  assign out_ch.valid    = ov;
  assign out_ch.value    = ovl;
  assign out_ch.last     = olast;
  assign out_ch.overflow = oovf;

  wire accept = in_ch.valid && in_ch.ready;
  wire [CW-1:0] lsize = CW'(low_end) - CW'(first);
  wire [CW-1:0] rsize = CW'(last) - CW'(low_end);
  wire idx_t mid_c = idx_t'((CW'(first) + CW'(last)) >> 1);
  wire pair = (mid == first);
  wire out_end = (CW'(oidx) + CW'(1) >= count);
  wire ov_load = (state == qsm3_pkg::ST_OUT_WAIT) && (!ov || out_ch.ready);
  wire sp_room = (sp < CW'(MAX_ITEMS));

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qsm3_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory port controls.
  always_comb begin
    state_next = state;
    we = 1'b0; wa = '0; wd = '0; ra = '0;
    swe = 1'b0; swd = '0;
    case (state)
      qsm3_pkg::ST_LOAD: begin
        we = accept && (count < CW'(MAX_ITEMS));
        wa = count[AW-1:0];
        wd = in_ch.value;
        if (accept && in_ch.last) begin
          state_next = (count >= CW'(1)) ? qsm3_pkg::ST_RANGE : qsm3_pkg::ST_OUT_RD;
        end
      end
      qsm3_pkg::ST_POP_REQ: begin
        state_next = (sp == '0) ? qsm3_pkg::ST_OUT_RD : qsm3_pkg::ST_POP_WAIT;
      end
      qsm3_pkg::ST_POP_WAIT: state_next = qsm3_pkg::ST_RANGE;
      qsm3_pkg::ST_RANGE: begin
        ra = first;
        state_next = (first >= last) ? qsm3_pkg::ST_POP_REQ : qsm3_pkg::ST_RD_MID;
      end
      qsm3_pkg::ST_RD_MID: begin
        ra = mid;
        state_next = qsm3_pkg::ST_RD_LAST;
      end
      qsm3_pkg::ST_RD_LAST: begin
        ra = last;
        state_next = qsm3_pkg::ST_CAP_LAST;
      end
      qsm3_pkg::ST_CAP_LAST: state_next = qsm3_pkg::ST_SORT_BC;
      qsm3_pkg::ST_SORT_BC: state_next = qsm3_pkg::ST_SORT_AB;
      qsm3_pkg::ST_SORT_AB: state_next = qsm3_pkg::ST_WR_FIRST;
      // Median goes to first, low to mid, high to last; a pair just sorts.
      qsm3_pkg::ST_WR_FIRST: begin
        we = 1'b1; wa = first; wd = pair ? a : b;
        state_next = pair ? qsm3_pkg::ST_WR_LAST : qsm3_pkg::ST_WR_MID;
      end
      qsm3_pkg::ST_WR_MID: begin
        we = 1'b1; wa = mid; wd = a;
        state_next = qsm3_pkg::ST_WR_LAST;
      end
      qsm3_pkg::ST_WR_LAST: begin
        we = 1'b1; wa = last; wd = c;
        state_next = pair ? qsm3_pkg::ST_POP_REQ : qsm3_pkg::ST_PT_RD;
      end
      qsm3_pkg::ST_PT_RD: begin
        ra = k;
        state_next = qsm3_pkg::ST_PT_CMP;
      end
      // rd holds store[k]; a smaller value is swapped down to low_end.
      qsm3_pkg::ST_PT_CMP: begin
        if (rd < pivot) begin
          ra = low_end + idx_t'(1);
          state_next = qsm3_pkg::ST_PT_SW;
        end else if (k == last) begin
          state_next = qsm3_pkg::ST_FIN_RD;
        end else begin
          ra = k + idx_t'(1);
          state_next = qsm3_pkg::ST_PT_CMP;
        end
      end
      qsm3_pkg::ST_PT_SW: begin
        // rd holds store[low_end]; a holds store[k].
        we = 1'b1; wa = k; wd = rd;
        state_next = qsm3_pkg::ST_PT_SW2;
      end
      qsm3_pkg::ST_PT_SW2: begin
        we = 1'b1; wa = low_end; wd = a;
        if (k == last) begin
          state_next = qsm3_pkg::ST_FIN_RD;
        end else begin
          ra = k + idx_t'(1);
          state_next = qsm3_pkg::ST_PT_CMP;
        end
      end
      // Move the pivot from first to its final place.
      qsm3_pkg::ST_FIN_RD: begin
        ra = low_end;
        state_next = qsm3_pkg::ST_FIN_WR;
      end
      qsm3_pkg::ST_FIN_WR: begin
        we = 1'b1; wa = first; wd = rd;
        state_next = qsm3_pkg::ST_FIN_WR2;
      end
      qsm3_pkg::ST_FIN_WR2: begin
        we = 1'b1; wa = low_end; wd = pivot;
        state_next = qsm3_pkg::ST_PUSH1;
      end
      qsm3_pkg::ST_PUSH1: begin
        swd = (lsize >= rsize) ? {first, low_end - idx_t'(1)}
                               : {low_end + idx_t'(1), last};
        swe = ((lsize >= rsize) ? (lsize > CW'(1)) : (rsize > CW'(1))) && sp_room;
        state_next = qsm3_pkg::ST_PUSH2;
      end
      qsm3_pkg::ST_PUSH2: begin
        swd = (lsize >= rsize) ? {low_end + idx_t'(1), last}
                               : {first, low_end - idx_t'(1)};
        swe = ((lsize >= rsize) ? (rsize > CW'(1)) : (lsize > CW'(1))) && sp_room;
        state_next = qsm3_pkg::ST_POP_REQ;
      end
      qsm3_pkg::ST_OUT_RD: begin
        ra = oidx;
        state_next = qsm3_pkg::ST_OUT_WAIT;
      end
      qsm3_pkg::ST_OUT_WAIT: begin
        ra = oidx;
        if (ov_load) state_next = out_end ? qsm3_pkg::ST_LOAD : qsm3_pkg::ST_OUT_RD;
      end
      default: state_next = qsm3_pkg::ST_LOAD;
    endcase
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (ov_load) begin
      ov <= 1'b1;
    end else if (out_ch.ready) begin
      ov <= 1'b0;
    end
  end

  // Sequencer data path.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      sp    <= '0;
    end else begin
      case (state)
        qsm3_pkg::ST_LOAD: begin
          if (accept) begin
            if (count < CW'(MAX_ITEMS)) count <= count + CW'(1);
            else ovf <= 1'b1;
            if (in_ch.last) begin
              first <= '0;
              last  <= (count < CW'(MAX_ITEMS)) ? count[AW-1:0] : idx_t'(MAX_ITEMS - 1);
              oidx  <= '0;
            end
          end
        end
        qsm3_pkg::ST_POP_REQ: begin
          if (sp == '0) oidx <= '0;
          else sp <= sp - CW'(1);
        end
        qsm3_pkg::ST_POP_WAIT: begin
          first <= srd[2*AW-1:AW];
          last  <= srd[AW-1:0];
        end
        qsm3_pkg::ST_RANGE: mid <= mid_c;
        qsm3_pkg::ST_RD_MID: a <= rd;
        qsm3_pkg::ST_RD_LAST: b <= rd;
        // Three compare-and-swap steps leave a <= b <= c.
        qsm3_pkg::ST_CAP_LAST: begin
          c <= rd;
          if (a > b) begin a <= b; b <= a; end
        end
        qsm3_pkg::ST_SORT_BC: begin
          if (b > c) begin b <= c; c <= b; end
        end
        qsm3_pkg::ST_SORT_AB: begin
          if (a > b) begin a <= b; b <= a; end
        end
        qsm3_pkg::ST_WR_FIRST: begin
          pivot   <= b;
          low_end <= first;
          k       <= first + idx_t'(1);
        end
        qsm3_pkg::ST_PT_CMP: begin
          if (rd < pivot) begin
            a       <= rd;
            low_end <= low_end + idx_t'(1);
          end else if (k != last) begin
            k <= k + idx_t'(1);
          end
        end
        qsm3_pkg::ST_PT_SW2: begin
          if (k != last) k <= k + idx_t'(1);
        end
        qsm3_pkg::ST_PUSH1: if (swe) sp <= sp + CW'(1);
        qsm3_pkg::ST_PUSH2: if (swe) sp <= sp + CW'(1);
        qsm3_pkg::ST_OUT_WAIT: begin
          if (ov_load) begin
            ovl   <= rd;
            olast <= out_end;
            oovf  <= ovf;
            if (out_end) begin
              count <= '0;
              ovf   <= 1'b0;
              sp    <= '0;
            end else begin
              oidx <= oidx + idx_t'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

/* hw/rtl/qsm3_checker.sv */
// ----------------------------------------------------------------------------
// qsm3_checker
// Port-level checks of the sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "quicksort_median_of_three_sorter_unit_macros.svh"

module qsm3_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);
  `QS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `QS_ASSERT_IMP(a_no_overlap, clk, rst, out_valid && !out_last, !in_ready)
  `QS_ASSERT_NEXT(a_last_hold, clk, rst, out_valid && !out_ready, $stable(out_last))
endmodule

bind quicksort_median_of_three_sorter_unit qsm3_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.last)
);
